// ===== sv/iis_pkg.sv =====
// shared constants for the streaming integral image block
package iis_pkg;

   // default sizing of the top level
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_SUM_BITS   = 32;

   // stride ceiling and the column counter that covers it
   localparam int STRIDE_LIMIT = 4096;
   localparam int COL_BITS     = $clog2(STRIDE_LIMIT);

   // field widths
   localparam int PIXEL_BITS  = 8;
   localparam int POS_BITS    = 10;
   localparam int FW_BITS     = 11;
   localparam int FH_BITS     = 11;
   localparam int SS_BITS     = 13;
   localparam int CFG_BITS    = 13;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SOURCE_STRIDE = 2'd2;

   // register reset values
   localparam logic [FW_BITS-1:0] RST_FRAME_WIDTH   = 11'd320;
   localparam logic [FH_BITS-1:0] RST_FRAME_HEIGHT  = 11'd240;
   localparam logic [SS_BITS-1:0] RST_SOURCE_STRIDE = 13'd320;

endpackage

// ===== sv/iis_line_store.sv =====
// previous-row line store with registered read and clearing sweep after reset
module iis_line_store
   import iis_pkg::*;
#(
   parameter int DEPTH     = DEF_MAX_WIDTH,
   parameter int DATA_BITS = DEF_SUM_BITS,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clear_busy,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_wa;
   logic [DATA_BITS-1:0] mem_wd;

   // clearing sweep, one entry per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared between sweep and pipeline
   always_comb begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== sv/integral_image_stream.sv =====
// streaming integral image: running row sum plus stored value from the row above
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_pixel
//   rsp      out        rsp_valid/rsp_ready   rsp_sum rsp_column rsp_row rsp_frame_end
//   csr      in         csr_write             csr_index csr_wdata
//
// one pixel per cycle unless a held result backs up the adder stage; a result passes the adder
// stage and then the result register (line store read at accept, add and write back in the adder stage)
// a same-column write from the stage ahead is forwarded past the store read
// after reset all MAX_WIDTH line store entries are swept to zero, req_ready low
// a stalled result holds the adder stage; input stays open while a stage drains
module integral_image_stream
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int SUM_BITS   = DEF_SUM_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIXEL_BITS-1:0]   req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SUM_BITS-1:0]     rsp_sum,
   output logic [POS_BITS-1:0]     rsp_column,
   output logic [POS_BITS-1:0]     rsp_row,
   output logic                    rsp_frame_end,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);

   // configuration
   logic [FW_BITS-1:0]  fw_ff;
   logic [FH_BITS-1:0]  fh_ff;
   logic [SS_BITS-1:0]  ss_ff;
   logic [CFG_BITS-1:0] eff_w, eff_h, eff_s;

   // position counters
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                last_row, row_end, emit, frame_end;

   // adder stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic                  s1_emit_ff, s1_row_end_ff, s1_frame_end_ff, s1_first_ff;
   logic                  s1_byp_ff, s1_byp_in;
   logic [SUM_BITS-1:0]   s1_byp_val_ff;
   logic                  s1_adv;
   logic [SUM_BITS-1:0]   run_ff, run_in;
   logic [SUM_BITS-1:0]   run_new, above, val;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0] rsp_sum_ff;
   logic [POS_BITS-1:0] rsp_col_ff, rsp_row_ff;
   logic                rsp_fe_ff;

   // line store port
   logic                 clear_busy;
   logic [SUM_BITS-1:0]  rd_data;
   logic                 wr_en;
   logic                 accept;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= RST_FRAME_WIDTH;
         fh_ff <= RST_FRAME_HEIGHT;
         ss_ff <= RST_SOURCE_STRIDE;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:   fw_ff <= csr_wdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT:  fh_ff <= csr_wdata[FH_BITS-1:0];
            REG_SOURCE_STRIDE: ss_ff <= csr_wdata[SS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp the registers to their working ranges
   always_comb begin
      eff_w = CFG_BITS'(fw_ff);
      if (fw_ff == '0) begin
         eff_w = CFG_BITS'(1);
      end else if (CFG_BITS'(fw_ff) > CFG_BITS'(MAX_WIDTH)) begin
         eff_w = CFG_BITS'(MAX_WIDTH);
      end
      eff_h = CFG_BITS'(fh_ff);
      if (fh_ff == '0) begin
         eff_h = CFG_BITS'(1);
      end else if (CFG_BITS'(fh_ff) > CFG_BITS'(MAX_HEIGHT)) begin
         eff_h = CFG_BITS'(MAX_HEIGHT);
      end
      eff_s = ss_ff;
      if (ss_ff < eff_w) begin
         eff_s = eff_w;
      end else if (ss_ff > CFG_BITS'(STRIDE_LIMIT)) begin
         eff_s = CFG_BITS'(STRIDE_LIMIT);
      end
   end

   // handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   // position decode for the incoming pixel
   always_comb begin
      last_row  = (CFG_BITS'(row_ff) + 1'b1) >= eff_h;
      row_end   = (CFG_BITS'(col_ff) + 1'b1) >= eff_s;
      emit      = CFG_BITS'(col_ff) < eff_w;
      frame_end = last_row && ((CFG_BITS'(col_ff) + 1'b1) == eff_w);
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_BITS'(row_ff + 1'b1);
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // forward the write leaving the adder stage when it hits the column being read
   assign wr_en     = s1_adv && s1_emit_ff;
   assign s1_byp_in = wr_en && (s1_col_ff == col_ff);

   // adder stage control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= req_pixel;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_emit_ff      <= emit;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
         s1_first_ff     <= (row_ff == '0);
         s1_byp_ff       <= s1_byp_in;
         s1_byp_val_ff   <= val;
      end
   end

   // sum of the row so far plus the value above
   always_comb begin
      run_new = run_ff + SUM_BITS'(s1_pixel_ff);
      if (s1_first_ff) begin
         above = '0;
      end else if (s1_byp_ff) begin
         above = s1_byp_val_ff;
      end else begin
         above = rd_data;
      end
      val    = run_new + above;
      run_in = run_ff;
      if (s1_adv) begin
         if (s1_row_end_ff) begin
            run_in = '0;
         end else if (s1_emit_ff) begin
            run_in = run_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_emit_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_sum_ff <= val;
         rsp_col_ff <= POS_BITS'(s1_col_ff);
         rsp_row_ff <= POS_BITS'(s1_row_ff);
         rsp_fe_ff  <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_column    = rsp_col_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_frame_end = rsp_fe_ff;

   // previous-row values
   iis_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (SUM_BITS)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .rd_en      (accept),
      .rd_addr    (col_ff[ADDR_BITS-1:0]),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (s1_col_ff[ADDR_BITS-1:0]),
      .wr_data    (val)
   );

   // no pixel taken while the line store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !clear_busy)
      else $error("pixel accepted during line store clear");

   // a line store write always lands a result in the output register
   a_write_gives_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("line store written without a result");

   // a stalled adder stage keeps its item
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_pixel_ff)
                                    && $stable(s1_col_ff)))
      else $error("adder stage lost its item while stalled");

   // forwarding only when the column in the stage matches the column being read
   a_bypass_match: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_byp_in) |-> (s1_emit_ff && (s1_col_ff == col_ff)))
      else $error("bypass taken on a mismatched column");

endmodule
